// ===== sv/double_buffered_line_assembler_defines.svh =====
// assertion helpers shared by the line assembler modules
`ifndef DOUBLE_BUFFERED_LINE_ASSEMBLER_DEFINES_SVH
`define DOUBLE_BUFFERED_LINE_ASSEMBLER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DBLA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DBLA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dbla_pkg.sv =====
package dbla_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_TAKE = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [6:0] LINE_LIMIT_RESET = 7'd64;

    // per-item result info handed from the control stage to the output stage
    typedef struct packed {
        logic       line_ready;
        logic [6:0] line_length;
        logic       line_ended;
        logic       byte_dropped;
        logic       rd_hit;
    } t_meta;

endpackage

// ===== sv/dbla_if.sv =====
interface dbla_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] in_byte;
    logic [5:0] read_index;

    modport source (output valid, command, in_byte, read_index, input ready);
    modport sink   (input valid, command, in_byte, read_index, output ready);
endinterface

interface dbla_out_if;
    logic       valid;
    logic       ready;
    logic       line_ready;
    logic [6:0] line_length;
    logic [7:0] data_byte;
    logic       line_ended;
    logic       byte_dropped;

    modport source (output valid, line_ready, line_length, data_byte, line_ended,
                     byte_dropped, input ready);
    modport sink   (input valid, line_ready, line_length, data_byte, line_ended,
                     byte_dropped, output ready);
endinterface

interface dbla_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] line_limit;

    modport source (output valid, line_limit, input ready);
    modport sink   (input valid, line_limit, output ready);
endinterface

// ===== sv/dbla_line_mem.sv =====
module dbla_line_mem #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/dbla_ctrl.sv =====
`include "double_buffered_line_assembler_defines.svh"

module dbla_ctrl #(
    parameter int unsigned MAX_LINE = 64,
    parameter int unsigned AW       = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dbla_in_if.sink         i_in,
    dbla_cfg_if.sink        i_cfg,
    input  logic            i_take_ok,
    output logic            o_accept,
    output dbla_pkg::t_meta o_meta,
    output logic            o_wr_en,
    output logic [AW-1:0]   o_wr_addr,
    output logic [7:0]      o_wr_data,
    output logic            o_rd_en,
    output logic [AW-1:0]   o_rd_addr
);

    import dbla_pkg::*;

    // stored length can never exceed the 7-bit limit register
    localparam int unsigned MaxLim   = (MAX_LINE > 127) ? 127 : MAX_LINE;
    localparam logic [6:0]  MAX_LIM  = 7'(MaxLim);
    localparam logic [AW-1:0] BUF_BASE = AW'(MAX_LINE);

    logic [6:0] r_limit,    n_limit;
    logic [6:0] r_fill_pos, n_fill_pos;
    logic       r_fill_buf, n_fill_buf;
    logic [6:0] r_done_len, n_done_len;
    logic       r_pending,  n_pending;
    logic       r_sync,     n_sync;

    logic [6:0] eff_limit;
    logic       storing;

    assign i_in.ready  = i_take_ok;
    assign i_cfg.ready = 1'b1;
    assign o_accept    = i_in.valid && i_take_ok;

    always_comb begin
        eff_limit = (r_limit == 7'd0) ? 7'd1 : ((r_limit > MAX_LIM) ? MAX_LIM : r_limit);
        storing   = r_fill_pos < eff_limit;

        n_limit    = i_cfg.valid ? i_cfg.line_limit : r_limit;
        n_fill_pos = r_fill_pos;
        n_fill_buf = r_fill_buf;
        n_done_len = r_done_len;
        n_pending  = r_pending;
        n_sync     = r_sync;

        o_meta    = '0;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;
        o_wr_data = i_in.in_byte;
        // write side fills one half, read side serves the other
        o_wr_addr = r_fill_buf ? BUF_BASE + AW'(r_fill_pos) : AW'(r_fill_pos);
        o_rd_addr = r_fill_buf ? AW'(i_in.read_index) : BUF_BASE + AW'(i_in.read_index);

        if (o_accept) begin
            unique case (i_in.command)
                CMD_PUSH: begin
                    if (i_in.in_byte == CHAR_LF) begin
                        if (storing && r_fill_pos == 7'd0) begin
                            n_sync = 1'b1;
                        end else begin
                            n_done_len        = r_fill_pos;
                            n_fill_buf        = ~r_fill_buf;
                            n_fill_pos        = 7'd0;
                            n_pending         = 1'b1;
                            o_meta.line_ended = 1'b1;
                        end
                    end else if (!storing) begin
                        o_meta.byte_dropped = 1'b1;
                    end else if (i_in.in_byte != CHAR_CR) begin
                        o_wr_en    = 1'b1;
                        n_fill_pos = r_fill_pos + 7'd1;
                    end
                    o_meta.line_length = n_done_len;
                end
                CMD_TAKE: begin
                    if (r_sync && r_pending) begin
                        n_pending          = 1'b0;
                        o_meta.line_ready  = 1'b1;
                        o_meta.line_length = r_done_len;
                    end
                end
                CMD_READ: begin
                    o_meta.line_length = r_done_len;
                    // done length never exceeds the buffer size, so a hit stays in range
                    o_meta.rd_hit      = {1'b0, i_in.read_index} < r_done_len;
                    o_rd_en            = o_meta.rd_hit;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LINE_LIMIT_RESET;
            r_fill_pos <= 7'd0;
            r_fill_buf <= 1'b0;
            r_done_len <= 7'd0;
            r_pending  <= 1'b0;
            r_sync     <= 1'b0;
        end else begin
            r_limit    <= n_limit;
            r_fill_pos <= n_fill_pos;
            r_fill_buf <= n_fill_buf;
            r_done_len <= n_done_len;
            r_pending  <= n_pending;
            r_sync     <= n_sync;
        end
    end

    `DBLA_ASSERT_NOW(a_fill_pos_bound, i_clk, i_rst_n, 1'b1, r_fill_pos <= MAX_LIM,
        "fill position beyond buffer size")
    `DBLA_ASSERT_NOW(a_done_len_bound, i_clk, i_rst_n, 1'b1, r_done_len <= MAX_LIM,
        "completed length beyond buffer size")
    `DBLA_ASSERT_NEXT(a_close_swaps, i_clk, i_rst_n, o_accept && o_meta.line_ended,
        r_fill_buf != $past(r_fill_buf) && r_pending, "line close did not swap buffers")

endmodule

// ===== sv/dbla_out.sv =====
`include "double_buffered_line_assembler_defines.svh"

module dbla_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  dbla_pkg::t_meta i_meta,
    input  logic [7:0]      i_mem_q,
    output logic            o_can_load,
    dbla_out_if.source      o_out
);

    import dbla_pkg::*;

    // stage one waits for the memory read, stage two is the output register
    logic  r_s1_valid;
    t_meta r_s1_meta;

    logic       r_o_valid;
    logic       r_o_line_ready;
    logic [6:0] r_o_line_length;
    logic [7:0] r_o_data_byte;
    logic       r_o_line_ended;
    logic       r_o_byte_dropped;

    logic s1_adv;

    assign s1_adv     = r_s1_valid && (!r_o_valid || o_out.ready);
    assign o_can_load = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_meta <= i_meta;
        end
        if (s1_adv) begin
            r_o_line_ready   <= r_s1_meta.line_ready;
            r_o_line_length  <= r_s1_meta.line_length;
            r_o_data_byte    <= r_s1_meta.rd_hit ? i_mem_q : CHAR_NUL;
            r_o_line_ended   <= r_s1_meta.line_ended;
            r_o_byte_dropped <= r_s1_meta.byte_dropped;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.line_ready   = r_o_line_ready;
    assign o_out.line_length  = r_o_line_length;
    assign o_out.data_byte    = r_o_data_byte;
    assign o_out.line_ended   = r_o_line_ended;
    assign o_out.byte_dropped = r_o_byte_dropped;

    `DBLA_ASSERT_NOW(a_no_load_when_full, i_clk, i_rst_n,
        r_s1_valid && r_o_valid && !o_out.ready, !i_load, "transfer taken with both stages full")
    `DBLA_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, s1_adv, r_o_valid,
        "stage one advanced but output is empty")
    `DBLA_ASSERT_NOW(a_data_only_on_read, i_clk, i_rst_n,
        r_o_valid && (o_out.line_ready || o_out.line_ended || o_out.byte_dropped),
        o_out.data_byte == CHAR_NUL, "nonzero data on a non-read result")

endmodule

// ===== sv/double_buffered_line_assembler.sv =====
// Double-buffered line assembler.
// i_in carries commands (push a received byte, take the pending line, read a
// byte of the completed line); every accepted command gives exactly one result
// on o_out. i_cfg writes the line limit and is always ready; write it only
// while the block is idle.
// Characters live in one line memory split into two halves: the fill half
// takes pushed bytes, the other half serves reads. Closing a line swaps them.
// Throughput: one command per cycle while o_out is not stalled, set by the
// single write port and single read port of the line memory (one access per
// command). Each result passes the registered memory read and then the output
// register before it is valid on o_out.
// Stall: with o_out stalled, one more command is taken into the read stage,
// then i_in.ready drops until the output register drains.
// Reset: control state clears, the line limit returns to 64, no line is
// pending and the stream is unsynchronised. Memory contents are not cleared;
// reads only reach characters written since reset.
module double_buffered_line_assembler #(
    parameter int unsigned MAX_LINE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dbla_in_if.sink    i_in,
    dbla_cfg_if.sink   i_cfg,
    dbla_out_if.source o_out
);

    import dbla_pkg::*;

    localparam int unsigned AW = $clog2(2 * MAX_LINE);

    logic          accept;
    logic          can_load;
    t_meta         meta;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    mem_q;

    dbla_ctrl #(
        .MAX_LINE (MAX_LINE),
        .AW       (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_take_ok (can_load),
        .o_accept  (accept),
        .o_meta    (meta),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    dbla_line_mem #(
        .DEPTH (2 * MAX_LINE),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_q)
    );

    dbla_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_meta     (meta),
        .i_mem_q    (mem_q),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

// ===== sim/double_buffered_line_assembler_tb.sv =====
module double_buffered_line_assembler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbla_pkg::*;

    localparam int LINE_CAP = 64;
    localparam int CYCLE_LIMIT = 250000;
    localparam int DRAIN_CYCLES = 6;
    localparam int SHOWN_MISMATCHES = 10;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic       line_ready;
        logic [6:0] line_length;
        logic [7:0] data_byte;
        logic       line_ended;
        logic       byte_dropped;
    } t_line_result;

    class t_line_scoreboard;
        logic [7:0]   line_store [2*LINE_CAP];
        logic [6:0]   fill_pos;
        logic         fill_buf;
        logic [6:0]   done_len;
        logic         pending;
        logic         synced;
        logic [6:0]   limit;
        t_line_result expected_q[$];
        int           mismatches;

        function new();
            fill_pos = '0;
            fill_buf = 1'b0;
            done_len = '0;
            pending = 1'b0;
            synced = 1'b0;
            limit = LINE_LIMIT_RESET;
            mismatches = 0;
        endfunction

        function void set_limit(logic [6:0] value);
            limit = value;
        endfunction

        function void close_line();
            done_len = fill_pos;
            fill_buf = !fill_buf;
            fill_pos = '0;
            pending = 1'b1;
        endfunction

        // predict the one result of an accepted command
        function void note_command(logic [1:0] cmd, logic [7:0] in_byte, logic [5:0] idx);
            t_line_result r;
            int           lim;
            r = '0;
            lim = (limit == 0) ? 1 : ((limit > LINE_CAP) ? LINE_CAP : int'(limit));
            case (cmd)
                CMD_PUSH: begin
                    if (fill_pos < lim) begin
                        if (in_byte == CHAR_LF) begin
                            if (fill_pos == 0) begin
                                synced = 1'b1;
                            end else begin
                                close_line();
                                r.line_ended = 1'b1;
                            end
                        end else if (in_byte != CHAR_CR) begin
                            line_store[int'(fill_buf) * LINE_CAP + int'(fill_pos)] = in_byte;
                            fill_pos = fill_pos + 7'd1;
                        end
                    end else if (in_byte == CHAR_LF) begin
                        close_line();
                        r.line_ended = 1'b1;
                    end else begin
                        r.byte_dropped = 1'b1;
                    end
                    r.line_length = done_len;
                end
                CMD_TAKE: begin
                    if (synced && pending) begin
                        pending = 1'b0;
                        r.line_ready = 1'b1;
                        r.line_length = done_len;
                    end
                end
                CMD_READ: begin
                    r.line_length = done_len;
                    if (idx < done_len)
                        r.data_byte = line_store[int'(!fill_buf) * LINE_CAP + int'(idx)];
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(t_line_result got);
            t_line_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("unexpected result: ready=%0d len=%0d data=%02h ended=%0d dropped=%0d",
                             got.line_ready, got.line_length, got.data_byte,
                             got.line_ended, got.byte_dropped);
                return;
            end
            want = expected_q.pop_front();
            if (got.line_ready !== want.line_ready || got.line_length !== want.line_length ||
                got.data_byte !== want.data_byte || got.line_ended !== want.line_ended ||
                got.byte_dropped !== want.byte_dropped) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("mismatch: exp ready=%0d len=%0d data=%02h ended=%0d dropped=%0d,",
                             want.line_ready, want.line_length, want.data_byte,
                             want.line_ended, want.byte_dropped,
                             " got ready=%0d len=%0d data=%02h ended=%0d dropped=%0d",
                             got.line_ready, got.line_length, got.data_byte,
                             got.line_ended, got.byte_dropped);
            end
        endfunction

        function int waiting();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   gaps_on = 1'b1;
    int   cycle_count = 0;
    int   items_sent = 0;

    t_line_scoreboard sb = new();

    dbla_in_if  in_ch();
    dbla_out_if out_ch();
    dbla_cfg_if cfg_ch();

    double_buffered_line_assembler #(.MAX_LINE(LINE_CAP)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = !i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** double_buffered_line_assembler: FAILED **");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= !gaps_on || ($urandom_range(99) >= 36);
    end

    always @(posedge i_clk) begin : watch_transfers
        t_line_result got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_limit(cfg_ch.line_limit);
            if (in_ch.valid && in_ch.ready)
                sb.note_command(in_ch.command, in_ch.in_byte, in_ch.read_index);
            if (out_ch.valid && out_ch.ready) begin
                got.line_ready = out_ch.line_ready;
                got.line_length = out_ch.line_length;
                got.data_byte = out_ch.data_byte;
                got.line_ended = out_ch.line_ended;
                got.byte_dropped = out_ch.byte_dropped;
                sb.check_result(got);
            end
        end
    end

    task automatic put_item(input logic [1:0] cmd, input logic [7:0] in_byte,
                            input logic [5:0] idx);
        if (gaps_on) begin
            while ($urandom_range(99) < 36) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.in_byte <= in_byte;
        in_ch.read_index <= idx;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        // let the last transfer reach the scoreboard first
        @(posedge i_clk);
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [6:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.line_limit <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int         start;
        int         kind;
        int         len;
        int         reads;
        int         top;
        logic [7:0] b;
        logic [5:0] idx;
        start = items_sent;
        while (items_sent - start < count) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                // a full line with random text, then usually a take and some reads
                len = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12);
                for (int k = 0; k < len; k++) begin
                    b = 8'($urandom_range(255));
                    if (b == CHAR_LF) b = CHAR_CR;
                    put_item(CMD_PUSH, b, 6'($urandom_range(63)));
                end
                put_item(CMD_PUSH, CHAR_LF, 6'($urandom_range(63)));
                if ($urandom_range(3) != 0)
                    put_item(CMD_TAKE, 8'($urandom_range(255)), 6'($urandom_range(63)));
                reads = $urandom_range(3);
                for (int k = 0; k < reads; k++) begin
                    top = (sb.done_len + 1 > 63) ? 63 : sb.done_len + 1;
                    idx = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                   : 6'($urandom_range(top));
                    put_item(CMD_READ, 8'($urandom_range(255)), idx);
                end
            end else if (kind < 72) begin
                put_item(CMD_TAKE, 8'($urandom_range(255)), 6'($urandom_range(63)));
            end else if (kind < 86) begin
                put_item(CMD_READ, 8'($urandom_range(255)), 6'($urandom_range(63)));
            end else if (kind < 99) begin
                put_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                         6'($urandom_range(63)));
            end else begin
                drain_results();
            end
        end
    endtask

    initial begin : stimulus
        logic [6:0] limits [8];
        limits = '{7'd127, 7'd1, 7'd33, 7'd0, 7'd64, 7'd100, 7'd5, 7'd64};
        limits[7] = 7'($urandom_range(127));

        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.command <= CMD_PUSH;
        in_ch.in_byte <= '0;
        in_ch.read_index <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.line_limit <= LINE_LIMIT_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // before any line and before synchronization
        put_item(CMD_READ, 8'h00, 6'd0);
        put_item(CMD_TAKE, 8'h00, 6'd0);
        put_item(CMD_PUSH, 8'h41, 6'd0);
        put_item(CMD_PUSH, CHAR_CR, 6'd0);
        put_item(CMD_PUSH, 8'h42, 6'd0);
        put_item(CMD_PUSH, CHAR_LF, 6'd0);
        put_item(CMD_TAKE, 8'h00, 6'd0);
        // newline on an empty line only synchronizes
        put_item(CMD_PUSH, CHAR_LF, 6'd63);
        put_item(CMD_TAKE, 8'hFF, 6'd63);
        put_item(CMD_TAKE, 8'h00, 6'd0);
        put_item(CMD_READ, 8'h00, 6'd0);
        put_item(CMD_READ, 8'h00, 6'd1);
        put_item(CMD_READ, 8'hFF, 6'd2);
        // closing a line while one is pending replaces it
        put_item(CMD_PUSH, CHAR_NUL, 6'd0);
        put_item(CMD_PUSH, 8'hFF, 6'd0);
        put_item(CMD_PUSH, CHAR_LF, 6'd0);
        put_item(CMD_PUSH, 8'h78, 6'd0);
        put_item(CMD_PUSH, CHAR_LF, 6'd0);
        put_item(CMD_TAKE, 8'h00, 6'd0);
        put_item(CMD_UNKNOWN, 8'hFF, 6'd63);
        // limit lowered below the fill position
        put_item(CMD_PUSH, 8'h61, 6'd0);
        put_item(CMD_PUSH, 8'h62, 6'd0);
        put_item(CMD_PUSH, 8'h63, 6'd0);
        drain_results();
        write_limit(7'd2);
        put_item(CMD_PUSH, 8'h71, 6'd0);
        put_item(CMD_PUSH, CHAR_LF, 6'd0);
        // zero limit acts as one; carriage return on overflow is dropped
        drain_results();
        write_limit(7'd0);
        put_item(CMD_PUSH, 8'h61, 6'd0);
        put_item(CMD_PUSH, 8'h62, 6'd0);
        put_item(CMD_PUSH, CHAR_CR, 6'd0);
        put_item(CMD_PUSH, CHAR_LF, 6'd0);

        for (int p = 0; p < 8; p++) begin
            drain_results();
            write_limit(limits[p]);
            gaps_on = (p != 4);
            random_traffic(172);
        end
        gaps_on = 1'b1;
        drain_results();

        if (sb.mismatches == 0 && sb.waiting() == 0) begin
            $display("** double_buffered_line_assembler: PASSED **");
        end else begin
            $display("** double_buffered_line_assembler: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dbla_pkg.sv
sv/dbla_if.sv
sv/dbla_line_mem.sv
sv/dbla_ctrl.sv
sv/dbla_out.sv
sv/double_buffered_line_assembler.sv
sim/double_buffered_line_assembler_tb.sv
